### hw/rtl/pcsv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsv_pkg
// Types, chunk type codes and helpers shared by the chunk stream validator.
// ----------------------------------------------------------------------------
package pcsv_pkg;

	localparam int MaxChunks    = 16384;
	localparam int MaxDimension = 7680;
	localparam int QDepth       = 4;
	localparam int QAw          = $clog2(QDepth);

	// configuration register indexes
	localparam logic CFG_CANON  = 1'b0;
	localparam logic CFG_STRICT = 1'b1;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_CONTAINER = 3'd1;
	localparam logic [2:0] ERR_LIMITS    = 3'd2;
	localparam logic [2:0] ERR_COLOR     = 3'd3;
	localparam logic [2:0] ERR_ANIM      = 3'd4;
	localparam logic [2:0] ERR_CANON     = 3'd5;
	localparam logic [2:0] ERR_PRIVATE   = 3'd6;

	localparam logic [31:0] T_IHDR   = 32'h49484452;
	localparam logic [31:0] T_IDAT   = 32'h49444154;
	localparam logic [31:0] T_IEND   = 32'h49454E44;
	localparam logic [31:0] T_ACTL   = 32'h6163544C;
	localparam logic [31:0] T_FCTL   = 32'h6663544C;
	localparam logic [31:0] T_FDAT   = 32'h66644154;
	localparam logic [31:0] T_ICCP   = 32'h69434350;
	localparam logic [31:0] T_CICP   = 32'h63494350;
	localparam logic [31:0] T_MDCV_L = 32'h6D444376;
	localparam logic [31:0] T_CLLI_L = 32'h634C4C69;
	localparam logic [31:0] T_MDCV_U = 32'h6D444356;
	localparam logic [31:0] T_CLLI_U = 32'h634C4C49;
	localparam logic [31:0] T_SRGB   = 32'h73524742;
	localparam logic [31:0] T_GAMA   = 32'h67414D41;
	localparam logic [31:0] T_CHRM   = 32'h6348524D;
	localparam logic [31:0] T_EXIF   = 32'h65584966;
	localparam logic [31:0] T_TRNS   = 32'h74524E53;
	localparam logic [31:0] T_PLTE   = 32'h504C5445;
	localparam logic [31:0] T_SBIT   = 32'h73424954;
	localparam logic [31:0] T_PHYS   = 32'h70485973;

	// classified byte handed from front to back
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} qent_t;

	typedef struct packed {
		logic        accepted;
		logic [2:0]  error_code;
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic        alpha_present;
		logic        srgb_tagged;
	} verdict_t;

	function automatic logic [7:0] sig_byte(input logic [2:0] i);
		logic [7:0] r;
		unique case (i)
			3'd0: r = 8'd137;
			3'd1: r = 8'd80;
			3'd2: r = 8'd78;
			3'd3: r = 8'd71;
			3'd4: r = 8'd13;
			3'd5: r = 8'd10;
			3'd6: r = 8'd26;
			default: r = 8'd10;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] chrm_byte(input logic [4:0] i);
		logic [31:0] w;
		unique case (i[4:2])
			3'd0: w = 32'd31270;
			3'd1: w = 32'd32900;
			3'd2: w = 32'd64000;
			3'd3: w = 32'd33000;
			3'd4: w = 32'd30000;
			3'd5: w = 32'd60000;
			3'd6: w = 32'd15000;
			default: w = 32'd6000;
		endcase
		return w[8*(3-i[1:0]) +: 8];
	endfunction

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] x;
		x = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++)
			x = x[0] ? ((x >> 1) ^ 32'hEDB88320) : (x >> 1);
		return x;
	endfunction

endpackage

### hw/rtl/pcsv_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsv_front
// Accepts file bytes and pushes them into a short queue for the parser.
// ----------------------------------------------------------------------------
module pcsv_front import pcsv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       q_valid,
	output qent_t      q_data,
	input  logic       q_pop
);

	qent_t          mem_q [QDepth];
	logic [QAw-1:0] wp_q, rp_q;
	logic [QAw:0]   cnt_q;
	logic           push;

	assign in_ready = cnt_q != (QAw+1)'(QDepth);
	assign push     = in_valid && in_ready;
	assign q_valid  = cnt_q != '0;
	assign q_data   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= '{data: data_byte, last: last_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (q_pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QAw+1)'(push) - (QAw+1)'(q_pop);
		end
	end

endmodule

### hw/rtl/pcsv_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsv_back
// Chunk framing, crc check and policy rules; one byte per cycle while no verdict waits on v_ready.
// ----------------------------------------------------------------------------
module pcsv_back import pcsv_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     canonical_mode,
	input  logic     strict_output_checks,
	input  logic     q_valid,
	input  qent_t    q_data,
	output logic     q_pop,
	output logic     v_valid,
	output verdict_t v_data,
	input  logic     v_ready
);

	localparam logic [2:0] PH_SIG  = 3'd0;
	localparam logic [2:0] PH_LEN  = 3'd1;
	localparam logic [2:0] PH_TYPE = 3'd2;
	localparam logic [2:0] PH_DATA = 3'd3;
	localparam logic [2:0] PH_CRC  = 3'd4;
	localparam logic [2:0] PH_DEAD = 3'd5;

	logic [2:0]  phase_q;
	logic [31:0] idx_q, len_q, type_q, crc_q, sh_q;
	logic [12:0] w_q, h_q;
	logic [14:0] cnt_q;
	logic        f_hdr_q, f_pix_q, f_srgb_q, f_gama_q, f_chrm_q, f_alpha_q, f_done_q;
	logic [2:0]  code_q;
	logic [7:0]  cap_q [13];
	logic        chrm_bad_q;

	logic [7:0]  b;
	logic        lst, step;
	logic [31:0] shn, cw0, cw4;
	logic [2:0]  rule;
	logic        set_hdr, set_pix, set_srgb, set_gama, set_chrm, set_alpha, set_done;
	logic        ok;
	logic [2:0]  vcode;

	assign b     = q_data.data;
	assign lst   = q_data.last;
	assign step  = q_valid && (!v_valid || v_ready);
	assign q_pop = step;
	assign shn   = {sh_q[23:0], b};
	assign cw0   = {cap_q[0], cap_q[1], cap_q[2], cap_q[3]};
	assign cw4   = {cap_q[4], cap_q[5], cap_q[6], cap_q[7]};

	// content rules of a chunk whose crc matched
	always_comb begin
		logic canon, strict, strc;
		logic [31:0] t;
		logic [63:0] px;
		canon = canonical_mode;
		strict = strict_output_checks;
		t = type_q;
		px = 64'(cw0) * 64'(cw4);
		rule = ERR_NONE;
		set_hdr = 1'b0; set_pix = 1'b0; set_srgb = 1'b0; set_gama = 1'b0;
		set_chrm = 1'b0; set_alpha = 1'b0; set_done = 1'b0;
		strc = t == T_PLTE || t == T_SBIT || t == T_PHYS;
		priority if (!f_hdr_q && t != T_IHDR) rule = ERR_CONTAINER;
		else if (t == T_ACTL || t == T_FCTL || t == T_FDAT) rule = ERR_ANIM;
		else if (t == T_ICCP || t == T_CICP || t == T_MDCV_L || t == T_CLLI_L ||
			t == T_MDCV_U || t == T_CLLI_U) rule = ERR_COLOR;
		else if (t == T_IHDR) begin
			priority if (f_hdr_q || cnt_q != 15'd1 || len_q != 32'd13) rule = ERR_CONTAINER;
			else if (cw0 == 0 || cw4 == 0 || cw0 > MaxDimension || cw4 > MaxDimension ||
				px > 64'd33177600) rule = ERR_LIMITS;
			else if (cap_q[8] != 8'd8 ||
				(cap_q[9] != 8'd2 && cap_q[9] != 8'd3 && cap_q[9] != 8'd6)) rule = ERR_COLOR;
			else if (cap_q[10] != 0 || cap_q[11] != 0 || cap_q[12] > 8'd1) rule = ERR_CONTAINER;
			else begin
				set_alpha = cap_q[9] == 8'd6;
				set_hdr = 1'b1;
				if ((canon || strict) && cap_q[9] != 8'd2) rule = ERR_CANON;
				else if (lst) rule = ERR_CONTAINER;
			end
		end else if (t == T_SRGB) begin
			if (f_srgb_q || len_q != 32'd1 || cap_q[0] > 8'd3) rule = ERR_COLOR;
			else begin set_srgb = 1'b1; if (lst) rule = ERR_CONTAINER; end
		end else if (t == T_GAMA) begin
			if (f_gama_q || len_q != 32'd4 || cw0 != 32'd45455) rule = ERR_COLOR;
			else begin set_gama = 1'b1; if (lst) rule = ERR_CONTAINER; end
		end else if (t == T_CHRM) begin
			if (f_chrm_q || len_q != 32'd32 || chrm_bad_q) rule = ERR_COLOR;
			else begin set_chrm = 1'b1; if (lst) rule = ERR_CONTAINER; end
		end else if (t == T_EXIF) begin
			if (canon) rule = ERR_PRIVATE;
			else if (lst) rule = ERR_CONTAINER;
		end else if (t == T_TRNS) begin
			set_alpha = 1'b1;
			if (canon || strict) rule = ERR_CANON;
			else if (lst) rule = ERR_CONTAINER;
		end else if (t == T_IDAT) begin
			set_pix = len_q != 0;
			if (lst) rule = ERR_CONTAINER;
		end else if (t == T_IEND) begin
			if (len_q != 0 || !f_pix_q || !lst) rule = ERR_CONTAINER;
			else if (canon && !f_srgb_q) rule = ERR_COLOR;
			else set_done = 1'b1;
		end else begin
			if (canon && !strc) rule = ERR_PRIVATE;
			else if (!t[29] && t != T_PLTE) rule = ERR_CONTAINER;
			else if (lst) rule = ERR_CONTAINER;
		end
	end

	// verdict of the final byte, seen on the state after this byte
	always_comb begin
		logic crc_end, cok, d;
		logic [2:0] fc;
		crc_end = phase_q == PH_CRC && idx_q == 32'd3;
		cok = shn == ~crc_q;
		fc = code_q;
		d = f_done_q;
		unique case (phase_q)
			PH_SIG: if (b != sig_byte(idx_q[2:0])) fc = ERR_CONTAINER;
			PH_LEN: if (idx_q == 0 && cnt_q >= MaxChunks) fc = ERR_CONTAINER;
			default: ;
		endcase
		if (crc_end) begin
			if (!cok) fc = ERR_CONTAINER;
			else if (rule != ERR_NONE) fc = rule;
			else d = d | set_done;
		end
		ok = fc == ERR_NONE && d;
		vcode = ok ? ERR_NONE : (fc != ERR_NONE ? fc : ERR_CONTAINER);
	end

	always_ff @(posedge clk) begin
		if (step && lst) begin
			v_data.accepted      <= ok;
			v_data.error_code    <= vcode;
			v_data.image_width   <= ok ? w_q : 13'd0;
			v_data.image_height  <= ok ? h_q : 13'd0;
			v_data.alpha_present <= ok && (f_alpha_q || set_alpha);
			v_data.srgb_tagged   <= ok && (f_srgb_q || set_srgb);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_valid <= 1'b0;
		end else if (step && lst) begin
			v_valid <= 1'b1;
		end else if (v_ready) begin
			v_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIG; idx_q <= '0; len_q <= '0; type_q <= '0; crc_q <= '1;
			sh_q <= '0; w_q <= '0; h_q <= '0; cnt_q <= '0; code_q <= '0;
			f_hdr_q <= 1'b0; f_pix_q <= 1'b0; f_srgb_q <= 1'b0; f_gama_q <= 1'b0;
			f_chrm_q <= 1'b0; f_alpha_q <= 1'b0; f_done_q <= 1'b0; chrm_bad_q <= 1'b0;
			for (int i = 0; i < 13; i++) cap_q[i] <= '0;
		end else if (step && lst) begin
			// new file starts after the verdict
			phase_q <= PH_SIG; idx_q <= '0; len_q <= '0; type_q <= '0; crc_q <= '1;
			sh_q <= '0; w_q <= '0; h_q <= '0; cnt_q <= '0; code_q <= '0;
			f_hdr_q <= 1'b0; f_pix_q <= 1'b0; f_srgb_q <= 1'b0; f_gama_q <= 1'b0;
			f_chrm_q <= 1'b0; f_alpha_q <= 1'b0; f_done_q <= 1'b0; chrm_bad_q <= 1'b0;
			for (int i = 0; i < 13; i++) cap_q[i] <= '0;
		end else if (step) begin
			unique case (phase_q)
				PH_SIG: begin
					if (b != sig_byte(idx_q[2:0])) begin
						code_q <= ERR_CONTAINER; phase_q <= PH_DEAD;
					end else if (idx_q == 32'd7) begin
						phase_q <= PH_LEN; idx_q <= '0;
					end else idx_q <= idx_q + 1;
				end
				PH_LEN: begin
					if (idx_q == 0 && cnt_q >= MaxChunks) begin
						code_q <= ERR_CONTAINER; phase_q <= PH_DEAD;
					end else begin
						if (idx_q == 0) cnt_q <= cnt_q + 1'b1;
						sh_q <= shn;
						if (idx_q == 32'd3) begin
							len_q <= shn; crc_q <= '1; phase_q <= PH_TYPE; idx_q <= '0;
						end else idx_q <= idx_q + 1;
					end
				end
				PH_TYPE: begin
					crc_q <= crc_byte(crc_q, b);
					sh_q <= shn;
					if (idx_q == 32'd3) begin
						type_q <= shn;
						for (int i = 0; i < 13; i++) cap_q[i] <= '0;
						chrm_bad_q <= 1'b0;
						phase_q <= (len_q != 0) ? PH_DATA : PH_CRC;
						idx_q <= '0;
					end else idx_q <= idx_q + 1;
				end
				PH_DATA: begin
					crc_q <= crc_byte(crc_q, b);
					if (idx_q < 13) cap_q[idx_q[3:0]] <= b;
					if (idx_q < 32 && chrm_byte(idx_q[4:0]) != b) chrm_bad_q <= 1'b1;
					if (idx_q + 1 == len_q) begin
						phase_q <= PH_CRC; idx_q <= '0;
					end else idx_q <= idx_q + 1;
				end
				PH_CRC: begin
					sh_q <= shn;
					if (idx_q == 32'd3) begin
						idx_q <= '0;
						if (shn != ~crc_q) begin
							code_q <= ERR_CONTAINER; phase_q <= PH_DEAD;
						end else begin
							if (set_hdr) begin w_q <= cw0[12:0]; h_q <= cw4[12:0]; end
							f_hdr_q <= f_hdr_q | set_hdr;
							f_pix_q <= f_pix_q | set_pix;
							f_srgb_q <= f_srgb_q | set_srgb;
							f_gama_q <= f_gama_q | set_gama;
							f_chrm_q <= f_chrm_q | set_chrm;
							f_alpha_q <= f_alpha_q | set_alpha;
							f_done_q <= f_done_q | set_done;
							if (rule != ERR_NONE) begin
								code_q <= rule; phase_q <= PH_DEAD;
							end else phase_q <= set_done ? PH_DEAD : PH_LEN;
						end
					end else idx_q <= idx_q + 1;
				end
				default: ;
			endcase
		end
	end

endmodule

### hw/rtl/png_chunk_stream_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_chunk_stream_validator
// Validates a PNG byte stream: signature, chunk framing, crc and file policy.
// ----------------------------------------------------------------------------
// throughput: one byte per cycle while no verdict waits on out_ready; each byte's crc update is combinational
// verdict path: the last byte is written into the queue, then the verdict is registered
// in the output register when the parser pops that byte from the queue
// input stalls while the 4-entry queue is full; the queue fills only while a verdict waits on out_ready
// reset: parser back to signature phase, queue and output empty, registers 0 except the crc register, which is all ones
module png_chunk_stream_validator import pcsv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        accepted,
	output logic [2:0]  error_code,
	output logic [12:0] image_width,
	output logic [12:0] image_height,
	output logic        alpha_present,
	output logic        srgb_tagged
);

	logic     canon_q, strict_q;
	logic     q_valid, q_pop;
	qent_t    q_data;
	verdict_t v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canon_q  <= 1'b0;
			strict_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_CANON) canon_q <= cfg_data;
			else strict_q <= cfg_data;
		end
	end

	pcsv_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .last_byte(last_byte),
		.q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
	);

	pcsv_back u_back (
		.clk(clk), .arst_n(arst_n), .canonical_mode(canon_q),
		.strict_output_checks(strict_q), .q_valid(q_valid), .q_data(q_data),
		.q_pop(q_pop), .v_valid(out_valid), .v_data(v), .v_ready(out_ready)
	);

	assign accepted      = v.accepted;
	assign error_code    = v.error_code;
	assign image_width   = v.image_width;
	assign image_height  = v.image_height;
	assign alpha_present = v.alpha_present;
	assign srgb_tagged   = v.srgb_tagged;

endmodule
